### rtl/membership_set_table_macros.svh
// Assertion helpers shared by the RTL.
`ifndef MEMBERSHIP_SET_TABLE_MACROS_SVH
`define MEMBERSHIP_SET_TABLE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define MST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define MST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/mst_pkg.sv
package mst_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned COUNT_OUT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Lookup token walking the cell row.
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
    logic               hit;   // a cell upstream holds the value
    logic               free;  // a cell upstream is empty
  } token_t;

  // Commit broadcast to every cell once the lookup is done.
  typedef struct packed {
    logic               ins;   // fill the first free cell
    logic               rem;   // clear the matching cell
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

### rtl/mst_ifs.sv
interface mst_req_if;
  logic                               valid;
  logic                               ready;
  logic [mst_pkg::OP_W-1:0]           op;
  logic signed [mst_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface mst_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             was_present;
  logic                             status;
  logic [mst_pkg::COUNT_OUT_W-1:0]  element_count;

  modport source (output valid, output was_present, output status, output element_count,
                  input ready);
  modport sink (input valid, input was_present, input status, input element_count,
                output ready);
endinterface

### rtl/membership_set_table.sv
// The lookup token walks one cell per cycle along the row of CAPACITY cells, then the
//   lookup is latched and then committed along with the response; the commit waits while
//   the response stalls. A new request is taken only after the previous one commits.
// Reset (rst, synchronous): all entries invalid, count zero, no request in flight.
// Stored values are not cleared; no clearing pass, ready right after reset.
module membership_set_table #(
  parameter int unsigned CAPACITY = mst_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  mst_req_if.sink   req,
  mst_rsp_if.source rsp
);

`include "membership_set_table_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [mst_pkg::OP_W-1:0]    op;
  logic                        pend_hit;
  logic                        pend_free;
  logic [mst_pkg::VALUE_W-1:0] pend_value;
  logic [CW-1:0]               count;
  logic                        rsp_valid;
  logic                        rsp_present;
  logic                        rsp_status;
  logic [CW-1:0]               rsp_count;

  mst_pkg::token_t             chain [CAPACITY+1];
  mst_pkg::token_t             tail;
  mst_pkg::cmd_t               cmd;

  logic accept;
  logic rsp_free;
  logic finish;
  logic do_ins;
  logic do_rem;
  logic refused;
  logic [CW-1:0] count_next;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign finish    = (state == ST_DONE) && rsp_free;

  assign chain[0] = '{vld: accept, value: req.value, hit: 1'b0, free: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .cmd     (cmd)
    );
  end

  assign tail = chain[CAPACITY];

  assign do_ins  = finish && (op == mst_pkg::OP_INSERT) && !pend_hit && pend_free;
  assign refused = (op == mst_pkg::OP_INSERT) && !pend_hit && !pend_free;
  assign do_rem  = finish && (op == mst_pkg::OP_REMOVE) && pend_hit;
  assign cmd     = '{ins: do_ins, rem: do_rem, value: pend_value};

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem && (count != '0)) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_BUSY;
      ST_BUSY: if (tail.vld) state_next = ST_DONE;
      ST_DONE: if (rsp_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req.op;
    end
    if ((state == ST_BUSY) && tail.vld) begin
      pend_hit   <= tail.hit;
      pend_free  <= tail.free;
      pend_value <= tail.value;
    end
    if (finish) begin
      rsp_present <= pend_hit;
      rsp_status  <= refused;
      rsp_count   <= count_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.was_present   = rsp_present;
  assign rsp.status        = rsp_status;
  assign rsp.element_count = mst_pkg::COUNT_OUT_W'(rsp_count);

  `MST_ASSERT_NOW(a_idle_chain_empty, clk, rst, req.ready, !tail.vld)
  `MST_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state == ST_BUSY)
  `MST_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `MST_ASSERT_NEXT(a_ins_count, clk, rst, do_ins, count == $past(count) + CW'(1))
  `MST_ASSERT_NOW(a_commit_excl, clk, rst, do_ins || do_rem, !(do_ins && do_rem))

endmodule

### rtl/mst_cell.sv
module mst_cell (
  input  logic            clk,
  input  logic            rst,
  input  mst_pkg::token_t tok_in,
  output mst_pkg::token_t tok_out,
  input  mst_pkg::cmd_t   cmd
);

  logic                        valid;
  logic [mst_pkg::VALUE_W-1:0] value;
  logic                        mark_hit;
  logic                        mark_free;
  logic                        tok_vld;
  logic [mst_pkg::VALUE_W-1:0] tok_value;
  logic                        tok_hit;
  logic                        tok_free;
  logic                        match;

  assign match = valid && (value == tok_in.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      mark_hit  <= 1'b0;
      mark_free <= 1'b0;
      tok_vld   <= 1'b0;
    end else begin
      tok_vld <= tok_in.vld;
      // marks record which cell is the first match / first hole for this beat
      if (tok_in.vld) begin
        mark_hit  <= match && !tok_in.hit;
        mark_free <= !valid && !tok_in.free;
      end
      if (cmd.ins && mark_free) begin
        valid <= 1'b1;
      end else if (cmd.rem && mark_hit) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_value <= tok_in.value;
    tok_hit   <= tok_in.hit || match;
    tok_free  <= tok_in.free || !valid;
    if (cmd.ins && mark_free) begin
      value <= cmd.value;
    end
  end

  assign tok_out = '{vld: tok_vld, value: tok_value, hit: tok_hit, free: tok_free};

endmodule

### tb/testbench.sv
module testbench;
  import mst_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned LATENCY    = CAP + 1;
  localparam int          STALL_MAX  = 500;
  localparam int          POOL_SIZE  = 20;
  localparam int          BLOCK_LEN  = 50;
  localparam int          RAND_ITEMS = 1650;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                   was_present;
    logic                   status;
    logic [COUNT_OUT_W-1:0] element_count;
  } reply_t;

  logic clk;
  logic rst;

  mst_req_if req_ch ();
  mst_rsp_if rsp_ch ();

  membership_set_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the table
  logic [VALUE_W-1:0] set_value [CAP];
  logic               set_used  [CAP];
  int unsigned        set_size;

  reply_t             expected_replies [$];
  int                 mismatches;
  int                 idle_cycles;
  bit                 calm;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reply_t apply_set_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    reply_t r;
    int     hit;
    int     slot;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < CAP; i++) begin
      if (set_used[i] && set_value[i] == value && hit < 0) hit = i;
      if (!set_used[i] && slot < 0) slot = i;
    end
    r.was_present = (hit >= 0);
    r.status      = 1'b0;
    if (op == OP_INSERT) begin
      if (hit < 0) begin
        if (slot >= 0) begin
          set_value[slot] = value;
          set_used[slot]  = 1'b1;
          set_size++;
        end else begin
          r.status = 1'b1;
        end
      end
    end else if (op == OP_REMOVE) begin
      if (hit >= 0) begin
        set_used[hit] = 1'b0;
        if (set_size > 0) set_size--;
      end
    end
    r.element_count = set_size[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Predicts on request beats, checks on response beats, and guards against hangs.
  always @(posedge clk) begin : monitor
    reply_t want;
    bit     moved;
    if (!rst) begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        expected_replies.push_back(apply_set_op(req_ch.op, req_ch.value));
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        if (expected_replies.size() == 0) begin
          $error("unexpected response beat: was_present %0d status %0d element_count %0d",
                 rsp_ch.was_present, rsp_ch.status, rsp_ch.element_count);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp_ch.was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, rsp_ch.was_present);
            mismatches++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, rsp_ch.element_count);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("[membership_set_table] ERROR");
        $finish;
      end
    end
  end

  // response side: random backpressure per beat
  initial begin : reply_sink
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(5);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  // Called and returns at a falling edge.
  task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(5);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op    = op;
    req_ch.value = value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic test_extremes();
    send_op(OP_SEARCH, 32'h0000_0000);   // empty table
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);   // duplicate is ignored
    send_op(OP_SEARCH, 32'h7FFF_FFFF);
    send_op(OP_SEARCH, 32'h0000_0005);
    send_op(OP_UNUSED, 32'hFFFF_FFFF);   // behaves as a search
  endtask

  task automatic test_removes();
    send_op(OP_REMOVE, 32'h8000_0000);   // entry zero
    send_op(OP_REMOVE, 32'h0000_3039);   // not there
    send_op(OP_REMOVE, 32'hFFFF_FFFF);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < CAP - 2; i++)
      send_op(OP_INSERT, 32'h5A5A_0000 + i);
    send_op(OP_INSERT, 32'hA5A5_A5A5);   // table full, refused
  endtask

  task automatic test_random_mix();
    int               mode;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [VALUE_W-1:0] value;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        mode = $urandom_range(2);
        calm = ($urandom_range(3) == 0);
      end
      pick = $urandom_range(99);
      case (mode)
        0: op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_SEARCH :
                (pick < 95) ? OP_REMOVE : OP_UNUSED;
        1: op = (pick < 65) ? OP_INSERT : (pick < 80) ? OP_SEARCH :
                (pick < 95) ? OP_REMOVE : OP_UNUSED;
        default: op = (pick < 20) ? OP_INSERT : (pick < 40) ? OP_SEARCH :
                      (pick < 95) ? OP_REMOVE : OP_UNUSED;
      endcase
      // mostly a small pool so that hits, refusals and removals are common
      value = ($urandom_range(99) < 85) ? value_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      send_op(op, value);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_SEARCH;
    req_ch.value = '0;
    calm         = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    set_size     = 0;
    for (int i = 0; i < CAP; i++) begin
      set_value[i] = '0;
      set_used[i]  = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_removes();
    test_overflow();
    test_random_mix();

    req_ch.valid = 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0)
      $display("[membership_set_table] OK");
    else
      $display("[membership_set_table] ERROR");
    $finish;
  end

endmodule
